FILE: rtl/core/cmam_pkg.sv
// Shared constants, types and helpers for the current moving-average monitor.
package cmam_pkg;

    // Window geometry and field widths
    localparam int WINDOW_DEPTH = 16;
    localparam int ADC_BITS     = 12;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = ADC_BITS + $clog2(WINDOW_DEPTH);
    localparam int GAIN_W       = 24;
    localparam int Q_W          = 36;
    localparam int CFG_W        = 36;
    localparam int PROD_W       = SUM_W + GAIN_W;
    localparam int VPROD_W      = ADC_BITS + GAIN_W;
    localparam int WIDE_W       = 64;

    // Largest possible window sum
    localparam logic [SUM_W-1:0] SUM_MAX =
        SUM_W'(WINDOW_DEPTH * ((1 << ADC_BITS) - 1));

    // Register reset values
    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST      = GAIN_W'(10813);
    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST      = GAIN_W'(1049);
    localparam logic [Q_W-1:0]    CURRENT_THRESHOLD_RST = Q_W'(655);

    // Register map
    typedef enum logic [1:0] {
        REG_CURRENT_GAIN      = 2'd0,
        REG_VOLTAGE_GAIN      = 2'd1,
        REG_CURRENT_THRESHOLD = 2'd2
    } cfg_reg_t;

    // Window stage to scaling stage
    typedef struct packed {
        logic                valid;
        logic [SUM_W-1:0]    sum;
        logic [ADC_BITS-1:0] volt;
    } win_t;

    // Clamp a wide unsigned value to the Q.16 output range
    function automatic logic [Q_W-1:0] sat_q(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] lim;
        lim = WIDE_W'({Q_W{1'b1}});
        return (v > lim) ? {Q_W{1'b1}} : v[Q_W-1:0];
    endfunction

endpackage

FILE: rtl/core/cmam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/cmam_window.sv
// Sample window: circular buffer in RAM, entry valid bits and running sum.
module cmam_window
    import cmam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                adv,
    input  logic [ADC_BITS-1:0] current_sample,
    input  logic [ADC_BITS-1:0] voltage_sample,
    output win_t                win
);

    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        ptr_next;
    logic [WINDOW_DEPTH-1:0] fill_reg;

    logic                    s1_valid_reg;
    logic [ADC_BITS-1:0]     s1_cur_reg;
    logic [ADC_BITS-1:0]     s1_volt_reg;
    logic [PTR_W-1:0]        s1_slot_reg;
    logic                    s1_old_ok_reg;

    logic                    s2_valid_reg;
    logic [ADC_BITS-1:0]     s2_volt_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;

    logic [ADC_BITS-1:0]     old_raw;
    logic [ADC_BITS-1:0]     old_sample;
    logic                    wr_en;

    // Window storage
    cmam_ram #(
        .WIDTH (ADC_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_slot_reg),
        .wdata (s1_cur_reg),
        .re    (accept),
        .raddr (ptr_reg),
        .rdata (old_raw)
    );

    // Advance the slot pointer with wrap
    always_comb
    begin
        if (ptr_reg == PTR_W'(WINDOW_DEPTH - 1))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    // Drop the leaving sample, add the new one
    assign wr_en      = s1_valid_reg && adv;
    assign old_sample = s1_old_ok_reg ? old_raw : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(s1_cur_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg <= ptr_next;
            end
            if (wr_en)
            begin
                fill_reg[s1_slot_reg] <= 1'b1;
                sum_reg               <= sum_next;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Request payload through the window stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg    <= current_sample;
            s1_volt_reg   <= voltage_sample;
            s1_slot_reg   <= ptr_reg;
            s1_old_ok_reg <= fill_reg[ptr_reg];
        end
        if (wr_en)
        begin
            s2_volt_reg <= s1_volt_reg;
        end
    end

    assign win.valid = s2_valid_reg;
    assign win.sum   = sum_reg;
    assign win.volt  = s2_volt_reg;

    // Running sum stays within full-scale window
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("window sum out of range");

    // An accepted request reaches the read-data stage
    a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost before window update");

    // A stalled window update holds its slot
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_slot_reg))
        else $error("window slot changed under stall");

endmodule

FILE: rtl/core/cmam_scale.sv
// Gain scaling, threshold hold and output register.
module cmam_scale
    import cmam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  win_t              win,
    input  logic [GAIN_W-1:0] current_gain,
    input  logic [GAIN_W-1:0] voltage_gain,
    input  logic [Q_W-1:0]    current_threshold,
    output logic              out_valid,
    output logic [Q_W-1:0]    filtered_current,
    output logic              current_updated,
    output logic [Q_W-1:0]    scaled_voltage
);

    logic                  m_valid_reg;
    logic [PROD_W-1:0]     m_prod_reg;
    logic [VPROD_W-1:0]    m_vprod_reg;

    logic                  out_valid_reg;
    logic [Q_W-1:0]        held_reg;
    logic                  updated_reg;
    logic [Q_W-1:0]        volt_reg;

    logic [Q_W-1:0]        mean;
    logic                  taken;

    // Mean over the window, then compare against threshold
    assign mean  = sat_q(WIDE_W'(m_prod_reg / PROD_W'(WINDOW_DEPTH)));
    assign taken = (mean >= current_threshold);

    // Control state and held current
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else if (adv)
        begin
            m_valid_reg   <= win.valid;
            out_valid_reg <= m_valid_reg;
            if (m_valid_reg && taken)
            begin
                held_reg <= mean;
            end
        end
    end

    // Multiply stage and result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (win.valid)
            begin
                m_prod_reg  <= PROD_W'(win.sum) * PROD_W'(current_gain);
                m_vprod_reg <= VPROD_W'(win.volt) * VPROD_W'(voltage_gain);
            end
            if (m_valid_reg)
            begin
                updated_reg <= taken;
                volt_reg    <= sat_q(WIDE_W'(m_vprod_reg));
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign filtered_current = held_reg;
    assign current_updated  = updated_reg;
    assign scaled_voltage   = volt_reg;

    // A product taken on advance lands in the output register
    a_mult_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && m_valid_reg |=> out_valid_reg)
        else $error("scaled result lost");

    // Held current moves only when a result with threshold met is loaded
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && m_valid_reg) |=> $stable(held_reg))
        else $error("held current changed without a result");

endmodule

FILE: rtl/core/current_moving_average_monitor_core.sv
// Top level of the current moving-average monitor with threshold hold.
//
// Input channel: in_valid / in_stall carry one raw current sample and one raw
// voltage sample per request. Output channel: out_valid / out_stall carry the
// held window-mean current, an update flag and the scaled battery voltage.
// Each input request produces exactly one output request, in order.
// The RAM read happens at the accepting edge; the window sum update, the gain
// multiply and the output register follow in that order.
// Throughput: one request per cycle while the output is not stalled; the
// window RAM is read at the new slot while the previous request writes its
// slot back, so no bubble occurs.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; it drops as soon as the result is taken.
// Reset clears the slot pointer, the running sum, the held current and the
// per-entry valid bits, so the window reads as all zero; gains and threshold
// return to their defaults. Configuration writes take effect at once and are
// meant for an idle block.
module current_moving_average_monitor_core
    import cmam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ADC_BITS-1:0] current_sample,
    input  logic [ADC_BITS-1:0] voltage_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [Q_W-1:0]      filtered_current,
    output logic                current_updated,
    output logic [Q_W-1:0]      scaled_voltage,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [GAIN_W-1:0] current_gain_reg;
    logic [GAIN_W-1:0] voltage_gain_reg;
    logic [Q_W-1:0]    current_threshold_reg;

    logic              adv;
    logic              accept;
    win_t              win;

    // Advance unless a finished result is stalled
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg      <= CURRENT_GAIN_RST;
            voltage_gain_reg      <= VOLTAGE_GAIN_RST;
            current_threshold_reg <= CURRENT_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CURRENT_GAIN:      current_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_VOLTAGE_GAIN:      voltage_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_CURRENT_THRESHOLD: current_threshold_reg <= cfg_data[Q_W-1:0];
                default:               ;
            endcase
        end
    end

    cmam_window u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .adv            (adv),
        .current_sample (current_sample),
        .voltage_sample (voltage_sample),
        .win            (win)
    );

    cmam_scale u_scale (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .win               (win),
        .current_gain      (current_gain_reg),
        .voltage_gain      (voltage_gain_reg),
        .current_threshold (current_threshold_reg),
        .out_valid         (out_valid),
        .filtered_current  (filtered_current),
        .current_updated   (current_updated),
        .scaled_voltage    (scaled_voltage)
    );

endmodule
